// File: sv/acia_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ACIA serial port package
// Shared types, codes and constants of the serial port register block.
// ----------------------------------------------------------------------------
package acia_pkg;

    // Default ring depths; each ring holds one byte fewer than its depth.
    localparam int TX_DEPTH_DEF = 16;
    localparam int RX_DEPTH_DEF = 16;

    // Entries in the command queue between front end and back end.
    localparam int CMD_QUEUE_DEPTH = 4;

    // Item operations.
    typedef enum logic [1:0] {
        OP_BUS_READ  = 2'd0,
        OP_BUS_WRITE = 2'd1,
        OP_RECEIVE   = 2'd2,
        OP_DRAIN     = 2'd3
    } op_t;

    // Register offsets; offset 2 is unassigned.
    localparam logic [1:0] OFS_DATA       = 2'd0;
    localparam logic [1:0] OFS_STATUS     = 2'd1;
    localparam logic [1:0] OFS_UNASSIGNED = 2'd2;
    localparam logic [1:0] OFS_CONTROL    = 2'd3;

    // Status and control bit positions.
    localparam int STAT_RX_READY_BIT = 3;
    localparam int STAT_TX_READY_BIT = 4;
    localparam int CTL_TX_EN_BIT     = 0;
    localparam int CTL_RX_EN_BIT     = 1;

    // Result kinds.
    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_TX   = 1'b1;

    typedef struct packed {
        logic [1:0] opcode;
        logic [1:0] reg_offset;
        logic [7:0] wdata;
    } in_item_t;

    typedef struct packed {
        logic       result_kind;
        logic [7:0] result_byte;
        logic       is_last;
    } out_item_t;

    // Classified commands handed from the front end to the back end.
    typedef enum logic [3:0] {
        CMD_RD_STATUS,
        CMD_RD_DATA,
        CMD_RD_CONTROL,
        CMD_RD_OTHER,
        CMD_WR_DATA,
        CMD_WR_CONTROL,
        CMD_RECEIVE,
        CMD_DRAIN
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] data;
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RX_WAIT,
        ST_DRAIN_READ,
        ST_DRAIN_SEND
    } back_state_t;

    typedef struct packed {
        logic overrun;
        logic xmit_rdy;
        logic recv_rdy;
        logic tx_empty;
        logic rx_empty;
    } acia_status_t;

endpackage

// File: sv/acia_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module acia_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: sv/acia_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ACIA front end
// Accepts items, decodes opcode and offset into commands and registers them.
// ----------------------------------------------------------------------------
module acia_front
    import acia_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_item_t s_item,
    output logic     cmd_valid,
    input  logic     cmd_ready,
    output cmd_t     cmd
);

    logic      cmd_valid_reg;
    logic      cmd_valid_next;
    cmd_t      cmd_reg;
    cmd_t      cmd_next;
    logic      keep;
    logic      accept;

    assign s_ready = !cmd_valid_reg || cmd_ready;
    assign accept  = s_valid && s_ready;

    always_comb begin
        keep          = 1'b1;
        cmd_next.data = s_item.wdata;
        cmd_next.kind = CMD_DRAIN;
        case (op_t'(s_item.opcode))
            OP_BUS_READ: begin
                case (s_item.reg_offset)
                    OFS_DATA:    cmd_next.kind = CMD_RD_DATA;
                    OFS_STATUS:  cmd_next.kind = CMD_RD_STATUS;
                    OFS_CONTROL: cmd_next.kind = CMD_RD_CONTROL;
                    default:     cmd_next.kind = CMD_RD_OTHER;
                endcase
            end
            OP_BUS_WRITE: begin
                // Writes to the status register or the unassigned offset do nothing.
                case (s_item.reg_offset)
                    OFS_DATA:    cmd_next.kind = CMD_WR_DATA;
                    OFS_CONTROL: cmd_next.kind = CMD_WR_CONTROL;
                    default:     keep = 1'b0;
                endcase
            end
            OP_RECEIVE: cmd_next.kind = CMD_RECEIVE;
            OP_DRAIN:   cmd_next.kind = CMD_DRAIN;
            default:    keep = 1'b0;
        endcase
    end

    assign cmd_valid_next = accept ? keep : (cmd_valid_reg && !cmd_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_valid_reg <= 1'b0;
        end else begin
            cmd_valid_reg <= cmd_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg <= cmd_next;
        end
    end

    assign cmd_valid = cmd_valid_reg;
    assign cmd       = cmd_reg;

endmodule

// File: sv/acia_cmd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ACIA command queue
// Small first-in first-out queue of commands between front and back end.
// ----------------------------------------------------------------------------
module acia_cmd_queue
    import acia_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  cmd_t in_cmd,
    output logic out_valid,
    input  logic out_ready,
    output cmd_t out_cmd
);

    localparam int PTR_W = $clog2(CMD_QUEUE_DEPTH);
    localparam int CNT_W = $clog2(CMD_QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(CMD_QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CMD_QUEUE_DEPTH);

    cmd_t             entry_reg [CMD_QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign in_ready  = (count_reg != CNT_FULL);
    assign out_valid = (count_reg != '0);
    assign out_cmd   = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

// File: sv/acia_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ACIA back end
// Executes commands against the rings and registers, drives the result port.
// ----------------------------------------------------------------------------
module acia_back
    import acia_pkg::*;
#(
    parameter int TX_DEPTH = TX_DEPTH_DEF,
    parameter int RX_DEPTH = RX_DEPTH_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cmd_valid,
    output logic         cmd_ready,
    input  cmd_t         cmd,
    output logic         m_valid,
    input  logic         m_ready,
    output out_item_t    m_item,
    output acia_status_t status
);

    localparam int TX_PTR_W = $clog2(TX_DEPTH);
    localparam int RX_PTR_W = $clog2(RX_DEPTH);
    localparam logic [TX_PTR_W-1:0] TX_LAST = TX_PTR_W'(TX_DEPTH - 1);
    localparam logic [RX_PTR_W-1:0] RX_LAST = RX_PTR_W'(RX_DEPTH - 1);

    back_state_t         state_reg;
    back_state_t         state_next;
    logic [TX_PTR_W-1:0] tx_wr_ptr_reg;
    logic [TX_PTR_W-1:0] tx_wr_ptr_next;
    logic [TX_PTR_W-1:0] tx_rd_ptr_reg;
    logic [TX_PTR_W-1:0] tx_rd_ptr_next;
    logic [RX_PTR_W-1:0] rx_wr_ptr_reg;
    logic [RX_PTR_W-1:0] rx_wr_ptr_next;
    logic [RX_PTR_W-1:0] rx_rd_ptr_reg;
    logic [RX_PTR_W-1:0] rx_rd_ptr_next;
    logic                xmit_rdy_reg;
    logic                xmit_rdy_next;
    logic                recv_rdy_reg;
    logic                recv_rdy_next;
    logic                overrun_reg;
    logic                overrun_next;
    logic [7:0]          ctrl_byte_reg;
    logic [7:0]          ctrl_byte_next;
    logic                last_reg;
    logic                last_next;
    logic                m_valid_reg;
    logic                m_valid_next;
    out_item_t           m_item_reg;
    out_item_t           m_item_next;

    logic [TX_PTR_W-1:0] tx_wr_inc;
    logic [TX_PTR_W-1:0] tx_rd_inc;
    logic [RX_PTR_W-1:0] rx_wr_inc;
    logic [RX_PTR_W-1:0] rx_rd_inc;
    logic                tx_empty;
    logic                tx_full;
    logic                rx_empty;
    logic                rx_full;
    logic                tx_en;
    logic                rx_en;
    logic                out_free;
    logic                is_read;
    logic                take;
    logic [7:0]          status_byte;

    logic                tx_wr_en;
    logic                tx_rd_en;
    logic                rx_wr_en;
    logic                rx_rd_en;
    logic [7:0]          tx_rd_data;
    logic [7:0]          rx_rd_data;

    acia_ram #(
        .WIDTH (8),
        .DEPTH (TX_DEPTH)
    ) u_tx_ram (
        .aclk    (aclk),
        .wr_en   (tx_wr_en),
        .wr_addr (tx_wr_ptr_reg),
        .wr_data (cmd.data),
        .rd_en   (tx_rd_en),
        .rd_addr (tx_rd_ptr_reg),
        .rd_data (tx_rd_data)
    );

    acia_ram #(
        .WIDTH (8),
        .DEPTH (RX_DEPTH)
    ) u_rx_ram (
        .aclk    (aclk),
        .wr_en   (rx_wr_en),
        .wr_addr (rx_wr_ptr_reg),
        .wr_data (cmd.data),
        .rd_en   (rx_rd_en),
        .rd_addr (rx_rd_ptr_reg),
        .rd_data (rx_rd_data)
    );

    assign tx_wr_inc = (tx_wr_ptr_reg == TX_LAST) ? '0 : tx_wr_ptr_reg + 1'b1;
    assign tx_rd_inc = (tx_rd_ptr_reg == TX_LAST) ? '0 : tx_rd_ptr_reg + 1'b1;
    assign rx_wr_inc = (rx_wr_ptr_reg == RX_LAST) ? '0 : rx_wr_ptr_reg + 1'b1;
    assign rx_rd_inc = (rx_rd_ptr_reg == RX_LAST) ? '0 : rx_rd_ptr_reg + 1'b1;
    assign tx_empty  = (tx_wr_ptr_reg == tx_rd_ptr_reg);
    assign tx_full   = (tx_wr_inc == tx_rd_ptr_reg);
    assign rx_empty  = (rx_wr_ptr_reg == rx_rd_ptr_reg);
    assign rx_full   = (rx_wr_inc == rx_rd_ptr_reg);
    assign tx_en     = ctrl_byte_reg[CTL_TX_EN_BIT];
    assign rx_en     = ctrl_byte_reg[CTL_RX_EN_BIT];
    assign out_free  = !m_valid_reg || m_ready;

    // Register reads that answer at once need a free output slot before they are taken.
    assign is_read   = cmd.kind inside {CMD_RD_STATUS, CMD_RD_CONTROL, CMD_RD_OTHER,
                                        CMD_RD_DATA};
    assign take      = (state_reg == ST_IDLE) && cmd_valid && (!is_read || out_free);
    assign cmd_ready = take;

    always_comb begin
        status_byte                    = '0;
        status_byte[STAT_TX_READY_BIT] = xmit_rdy_reg;
        status_byte[STAT_RX_READY_BIT] = recv_rdy_reg;
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (take) begin
                    if (cmd.kind == CMD_RD_DATA && recv_rdy_reg) begin
                        state_next = ST_RX_WAIT;
                    end else if (cmd.kind == CMD_DRAIN && tx_en && !xmit_rdy_reg
                                 && !tx_empty) begin
                        state_next = ST_DRAIN_READ;
                    end
                end
            end
            ST_RX_WAIT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_DRAIN_READ: begin
                state_next = ST_DRAIN_SEND;
            end
            ST_DRAIN_SEND: begin
                if (out_free) begin
                    state_next = last_reg ? ST_IDLE : ST_DRAIN_READ;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and outputs
    always_comb begin
        tx_wr_ptr_next = tx_wr_ptr_reg;
        tx_rd_ptr_next = tx_rd_ptr_reg;
        rx_wr_ptr_next = rx_wr_ptr_reg;
        rx_rd_ptr_next = rx_rd_ptr_reg;
        xmit_rdy_next  = xmit_rdy_reg;
        recv_rdy_next  = recv_rdy_reg;
        overrun_next   = overrun_reg;
        ctrl_byte_next = ctrl_byte_reg;
        last_next      = last_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_item_next    = m_item_reg;
        tx_wr_en       = 1'b0;
        tx_rd_en       = 1'b0;
        rx_wr_en       = 1'b0;
        rx_rd_en       = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (take) begin
                    case (cmd.kind)
                        CMD_RD_STATUS: begin
                            m_valid_next = 1'b1;
                            m_item_next  = '{KIND_READ, status_byte, 1'b1};
                        end
                        CMD_RD_CONTROL: begin
                            m_valid_next = 1'b1;
                            m_item_next  = '{KIND_READ, ctrl_byte_reg, 1'b1};
                        end
                        CMD_RD_OTHER: begin
                            m_valid_next = 1'b1;
                            m_item_next  = '{KIND_READ, 8'h00, 1'b1};
                        end
                        CMD_RD_DATA: begin
                            if (recv_rdy_reg) begin
                                rx_rd_en       = 1'b1;
                                rx_rd_ptr_next = rx_rd_inc;
                                if (rx_rd_inc == rx_wr_ptr_reg) begin
                                    recv_rdy_next = 1'b0;
                                end
                            end else begin
                                m_valid_next = 1'b1;
                                m_item_next  = '{KIND_READ, 8'h00, 1'b1};
                            end
                        end
                        CMD_WR_DATA: begin
                            if (tx_en) begin
                                if (!tx_full) begin
                                    tx_wr_en       = 1'b1;
                                    tx_wr_ptr_next = tx_wr_inc;
                                    xmit_rdy_next  = 1'b0;
                                end else begin
                                    overrun_next = 1'b1;
                                end
                            end
                        end
                        CMD_WR_CONTROL: begin
                            ctrl_byte_next = cmd.data;
                            xmit_rdy_next  = cmd.data[CTL_TX_EN_BIT] && tx_empty;
                            recv_rdy_next  = cmd.data[CTL_RX_EN_BIT] && !rx_empty;
                        end
                        CMD_RECEIVE: begin
                            // A received byte is stored even with the receiver disabled.
                            if (rx_full) begin
                                overrun_next = 1'b1;
                            end else begin
                                rx_wr_en       = 1'b1;
                                rx_wr_ptr_next = rx_wr_inc;
                                recv_rdy_next  = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_RX_WAIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_item_next  = '{KIND_READ, rx_rd_data, 1'b1};
                end
            end
            ST_DRAIN_READ: begin
                tx_rd_en       = 1'b1;
                tx_rd_ptr_next = tx_rd_inc;
                last_next      = (tx_rd_inc == tx_wr_ptr_reg);
            end
            ST_DRAIN_SEND: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_item_next  = '{KIND_TX, tx_rd_data, last_reg};
                    if (last_reg) begin
                        xmit_rdy_next = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            tx_wr_ptr_reg <= '0;
            tx_rd_ptr_reg <= '0;
            rx_wr_ptr_reg <= '0;
            rx_rd_ptr_reg <= '0;
            xmit_rdy_reg  <= 1'b1;
            recv_rdy_reg  <= 1'b0;
            overrun_reg   <= 1'b0;
            ctrl_byte_reg <= '0;
            last_reg      <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            tx_wr_ptr_reg <= tx_wr_ptr_next;
            tx_rd_ptr_reg <= tx_rd_ptr_next;
            rx_wr_ptr_reg <= rx_wr_ptr_next;
            rx_rd_ptr_reg <= rx_rd_ptr_next;
            xmit_rdy_reg  <= xmit_rdy_next;
            recv_rdy_reg  <= recv_rdy_next;
            overrun_reg   <= overrun_next;
            ctrl_byte_reg <= ctrl_byte_next;
            last_reg      <= last_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_item_reg <= m_item_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_item          = m_item_reg;
    assign status.overrun  = overrun_reg;
    assign status.xmit_rdy = xmit_rdy_reg;
    assign status.recv_rdy = recv_rdy_reg;
    assign status.tx_empty = tx_empty;
    assign status.rx_empty = rx_empty;

endmodule

// File: sv/uart_acia_fifo_registers.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UART ACIA register block with TX and RX ring buffers
// Top level: front end decoder, command queue and execution back end.
// ----------------------------------------------------------------------------
// Each item is a bus read, a bus write, a received byte or a transmit drain
// tick. The front end registers and decodes items into a four-entry command
// queue, so items keep being accepted while the back end works or the result
// port stalls, until the queue fills. While idle, the back end takes one
// command per cycle for bus writes, received bytes and status or control
// reads (reads only while the result port is free); a data read with a byte
// waiting passes a wait state, as the RX ring sits in a RAM with registered
// read data. Likewise a drain tick sends each queued TX byte through a read
// and a send state. Each ring holds one byte fewer than its depth.
module uart_acia_fifo_registers
    import acia_pkg::*;
#(
    parameter int TX_DEPTH = TX_DEPTH_DEF,
    parameter int RX_DEPTH = RX_DEPTH_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    logic         front_valid;
    logic         front_ready;
    cmd_t         front_cmd;
    logic         queue_valid;
    logic         queue_ready;
    cmd_t         queue_cmd;
    acia_status_t status;

    acia_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .cmd_valid (front_valid),
        .cmd_ready (front_ready),
        .cmd       (front_cmd)
    );

    acia_cmd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_cmd    (front_cmd),
        .out_valid (queue_valid),
        .out_ready (queue_ready),
        .out_cmd   (queue_cmd)
    );

    acia_back #(
        .TX_DEPTH (TX_DEPTH),
        .RX_DEPTH (RX_DEPTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (queue_valid),
        .cmd_ready (queue_ready),
        .cmd       (queue_cmd),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .status    (status)
    );

`ifndef SYNTHESIS
    // Overrun is sticky until reset.
    assert property (@(posedge aclk) disable iff (!aresetn)
        status.overrun |=> status.overrun)
        else $error("overrun flag cleared without reset");

    // Receive ready is only ever set while the RX ring holds a byte.
    assert property (@(posedge aclk) disable iff (!aresetn)
        status.recv_rdy |-> !status.rx_empty)
        else $error("receive ready with empty RX ring");

    // Transmit ready means nothing is left queued for transmission.
    assert property (@(posedge aclk) disable iff (!aresetn)
        status.xmit_rdy |-> status.tx_empty)
        else $error("transmit ready with bytes still queued");

    // A bus read produces exactly one result item, so every read result is marked last.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_item.result_kind == KIND_READ)) |-> m_item.is_last)
        else $error("bus read result not marked last");
`endif

endmodule
